// File: hdl/gtpu_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// GTP-U tunnel flow counter. No dependencies.
`timescale 1ns / 1ps

package gtpu_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int HEADER_BYTES = 90;

  localparam logic [15:0] TUNNEL_PORT_RST = 16'd2152;
  localparam logic [15:0] MIN_LEN = 16'd34;
  localparam logic [6:0]  ETH_LEN = 7'd14;
  localparam logic [15:0] UDP_GTP_LEN = 16'd16;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TRACK = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] ST_NOT_GTP   = 3'd0;
  localparam logic [2:0] ST_UNTRACKED = 3'd1;
  localparam logic [2:0] ST_COUNTED   = 3'd2;
  localparam logic [2:0] ST_ADDED     = 3'd3;
  localparam logic [2:0] ST_ALREADY   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_READ_HIT  = 3'd6;
  localparam logic [2:0] ST_READ_MISS = 3'd7;

  typedef struct packed {
    logic scan_start;
    logic tid_rd;
    logic idx_inc;
    logic ctr_rd;
    logic fin_nongtp;
    logic fin_miss;
    logic fin_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic gtp_ok;
    logic at_end;
    logic match;
  } dp_sts_t;

endpackage

// File: hdl/gtpu_ctrl.sv
// Sequencer for the GTP-U flow counter: packet check, table scan, counter
// update. Depends on gtpu_pkg.
`timescale 1ns / 1ps

module gtpu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       kind_i,
  input  logic             last_byte_i,
  input  gtpu_pkg::dp_sts_t sts_i,
  output gtpu_pkg::dp_cmd_t cmd_o,
  output logic             busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;
  localparam logic [2:0] S_SCMP  = 3'd3;
  localparam logic [2:0] S_CUPD  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          if (kind_i == gtpu_pkg::KIND_BYTE) begin
            if (last_byte_i) state_d = S_CHECK;
          end else if (kind_i == gtpu_pkg::KIND_TRACK || kind_i == gtpu_pkg::KIND_READ) begin
            state_d = S_SRD;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.gtp_ok) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SRD;
        end else begin
          cmd_o.fin_nongtp = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SRD: begin
        if (sts_i.at_end) begin
          cmd_o.fin_miss = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.tid_rd = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts_i.match) begin
          cmd_o.ctr_rd = 1'b1;
          state_d = S_CUPD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_SRD;
        end
      end
      S_CUPD: begin
        cmd_o.fin_hit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !accept_i) else $error("accept while busy");
  a_cupd_follows_crd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_hit |-> $past(cmd_o.ctr_rd)) else $error("hit without counter read");
  a_single_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.fin_nongtp, cmd_o.fin_miss, cmd_o.fin_hit}))
    else $error("multiple finishes");

endmodule

// File: hdl/gtpu_dpath.sv
// Datapath for the GTP-U flow counter: header field capture, TEID table,
// counter memory and result registers. Depends on gtpu_pkg.
`timescale 1ns / 1ps

module gtpu_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [31:0]       tunnel_id_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  gtpu_pkg::dp_cmd_t cmd_i,
  output gtpu_pkg::dp_sts_t sts_o,
  output logic              result_valid_o,
  output logic [2:0]        status_o,
  output logic [31:0]       found_tunnel_id_o,
  output logic [63:0]       packet_total_o,
  output logic [63:0]       byte_total_o,
  output logic [15:0]       packet_length_o
);

  localparam logic [gtpu_pkg::CNT_W-1:0] ENTRIES_C =
    gtpu_pkg::CNT_W'(gtpu_pkg::TABLE_ENTRIES);

  logic [15:0] port_q;
  logic [15:0] pos_q, pos_inc, len_q, off;
  logic [7:0]  b12_q, b13_q, b23_q;
  logic [6:0]  u_q, u_cur;
  logic [15:0] sp_q, dp_q;
  logic [31:0] teid_q, key_q;
  logic [1:0]  kind_q;
  logic [gtpu_pkg::CNT_W-1:0] idx_q, count_q;
  logic        byte_acc;

  logic [31:0]  tid_mem [gtpu_pkg::TABLE_ENTRIES];
  logic [127:0] ctr_mem [gtpu_pkg::TABLE_ENTRIES];
  logic [31:0]  tid_rdata_q;
  logic [127:0] ctr_rdata_q;

  logic         tid_we, ctr_we, full;
  logic [127:0] ctr_wdata;
  logic [63:0]  pk_inc, by_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       port_q <= gtpu_pkg::TUNNEL_PORT_RST;
    else if (cfg_we_i) port_q <= cfg_wdata_i;
  end

  assign byte_acc = accept_i && (kind_i == gtpu_pkg::KIND_BYTE);
  assign pos_inc  = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
  assign u_cur    = (pos_q == 16'd14) ? gtpu_pkg::ETH_LEN + {1'b0, data_byte_i[3:0], 2'b00}
                                      : u_q;
  assign off      = pos_q - {9'd0, u_cur};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (byte_acc) begin
      pos_q <= last_byte_i ? 16'd0 : pos_inc;
    end
  end

  // header fields are picked off as the bytes stream past
  always_ff @(posedge clk_i) begin
    if (byte_acc) begin
      if (last_byte_i) len_q <= pos_inc;
      if (pos_q == 16'd12) b12_q <= data_byte_i;
      if (pos_q == 16'd13) b13_q <= data_byte_i;
      if (pos_q == 16'd23) b23_q <= data_byte_i;
      if (pos_q == 16'd14) u_q <= u_cur;
      if (pos_q >= {9'd0, u_cur} && off < 16'd16) begin
        unique case (off[3:0])
          4'd0:  sp_q[15:8]    <= data_byte_i;
          4'd1:  sp_q[7:0]     <= data_byte_i;
          4'd2:  dp_q[15:8]    <= data_byte_i;
          4'd3:  dp_q[7:0]     <= data_byte_i;
          4'd12: teid_q[31:24] <= data_byte_i;
          4'd13: teid_q[23:16] <= data_byte_i;
          4'd14: teid_q[15:8]  <= data_byte_i;
          4'd15: teid_q[7:0]   <= data_byte_i;
          default: ;
        endcase
      end
    end
  end

  assign sts_o.gtp_ok = (len_q >= gtpu_pkg::MIN_LEN) &&
                        ({b12_q, b13_q} == gtpu_pkg::ETYPE_IPV4) &&
                        (b23_q == gtpu_pkg::PROTO_UDP) &&
                        (len_q >= {9'd0, u_q} + gtpu_pkg::UDP_GTP_LEN) &&
                        (sp_q == port_q || dp_q == port_q);
  assign sts_o.at_end = (idx_q == count_q);
  assign sts_o.match  = (tid_rdata_q == key_q);
  assign full         = (count_q == ENTRIES_C);

  always_ff @(posedge clk_i) begin
    if (accept_i) kind_q <= kind_i;
    if (accept_i && kind_i != gtpu_pkg::KIND_BYTE) key_q <= tunnel_id_i;
    else if (cmd_i.scan_start) key_q <= teid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept_i || cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign tid_we = cmd_i.fin_miss && (kind_q == gtpu_pkg::KIND_TRACK) && !full;
  assign pk_inc = ctr_rdata_q[127:64] + 64'd1;
  assign by_inc = ctr_rdata_q[63:0] + {48'd0, len_q};
  assign ctr_we = tid_we || (cmd_i.fin_hit && kind_q == gtpu_pkg::KIND_BYTE);
  assign ctr_wdata = tid_we ? 128'd0 : {pk_inc, by_inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     count_q <= '0;
    else if (tid_we) count_q <= count_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (tid_we) tid_mem[count_q[gtpu_pkg::IDX_W-1:0]] <= key_q;
    if (cmd_i.tid_rd) tid_rdata_q <= tid_mem[idx_q[gtpu_pkg::IDX_W-1:0]];
  end

  // new entries land at count_q, hits update at idx_q
  always_ff @(posedge clk_i) begin
    if (ctr_we) ctr_mem[tid_we ? count_q[gtpu_pkg::IDX_W-1:0]
                               : idx_q[gtpu_pkg::IDX_W-1:0]] <= ctr_wdata;
    if (cmd_i.ctr_rd) ctr_rdata_q <= ctr_mem[idx_q[gtpu_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.fin_nongtp | cmd_i.fin_miss | cmd_i.fin_hit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_nongtp) begin
      status_o          <= gtpu_pkg::ST_NOT_GTP;
      found_tunnel_id_o <= '0;
      packet_total_o    <= '0;
      byte_total_o      <= '0;
      packet_length_o   <= len_q;
    end else if (cmd_i.fin_miss) begin
      found_tunnel_id_o <= key_q;
      packet_total_o    <= '0;
      byte_total_o      <= '0;
      if (kind_q == gtpu_pkg::KIND_BYTE) begin
        status_o        <= gtpu_pkg::ST_UNTRACKED;
        packet_length_o <= len_q;
      end else if (kind_q == gtpu_pkg::KIND_TRACK) begin
        status_o        <= full ? gtpu_pkg::ST_FULL : gtpu_pkg::ST_ADDED;
        packet_length_o <= '0;
      end else begin
        status_o        <= gtpu_pkg::ST_READ_MISS;
        packet_length_o <= '0;
      end
    end else if (cmd_i.fin_hit) begin
      found_tunnel_id_o <= key_q;
      if (kind_q == gtpu_pkg::KIND_BYTE) begin
        status_o        <= gtpu_pkg::ST_COUNTED;
        packet_total_o  <= pk_inc;
        byte_total_o    <= by_inc;
        packet_length_o <= len_q;
      end else begin
        status_o        <= (kind_q == gtpu_pkg::KIND_TRACK) ? gtpu_pkg::ST_ALREADY
                                                            : gtpu_pkg::ST_READ_HIT;
        packet_total_o  <= ctr_rdata_q[127:64];
        byte_total_o    <= ctr_rdata_q[63:0];
        packet_length_o <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ENTRIES_C) else $error("table count overflow");
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(cmd_i.fin_nongtp | cmd_i.fin_miss | cmd_i.fin_hit))
    else $error("result without finish");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tid_rd |-> (idx_q < count_q)) else $error("scan past table fill");

endmodule

// File: hdl/gtpu_teid_flow_counter.sv
// Top level of the GTP-U per-tunnel packet/byte counter: controller plus
// datapath. Depends on gtpu_pkg, gtpu_ctrl, gtpu_dpath.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  item in  | start & !busy               | kind_i data_byte_i last_byte_i tunnel_id_i
//  result   | result_valid_o (one cycle)  | status_o found_tunnel_id_o packet_total_o
//           |                             | byte_total_o packet_length_o
//  config   | cfg_we_i                    | cfg_wdata_i
//
// Packet bytes other than the last never raise busy.
// A last byte holds busy through a header check and, for a GTP-U packet, a table scan
// (a TEID read and a compare per entry) plus, on a hit, a counter update; a command
// the same without the check. The table scan sets how long busy lasts.
// Result is valid in the first cycle with busy low; the receiver cannot stall.
// Reset is asynchronous; the table needs no clearing pass (fill count).
`timescale 1ns / 1ps

module gtpu_teid_flow_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] tunnel_id_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_tunnel_id_o,
  output logic [63:0] packet_total_o,
  output logic [63:0] byte_total_o,
  output logic [15:0] packet_length_o
);

  gtpu_pkg::dp_cmd_t cmd;
  gtpu_pkg::dp_sts_t sts;
  logic accept;

  assign accept = start && !busy;

  gtpu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .last_byte_i (last_byte_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  gtpu_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .kind_i            (kind_i),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .tunnel_id_i       (tunnel_id_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .found_tunnel_id_o (found_tunnel_id_o),
    .packet_total_o    (packet_total_o),
    .byte_total_o      (byte_total_o),
    .packet_length_o   (packet_length_o)
  );

endmodule

// File: verif/tb_gtpu_teid_flow_counter.sv
// Self-checking testbench for gtpu_teid_flow_counter: random and directed packet
// bytes and table commands, checked against an in-bench flow table model.
// Depends on gtpu_pkg and the gtpu_teid_flow_counter RTL.
`timescale 1ns / 1ps

module tb_gtpu_teid_flow_counter;

  localparam int PAUSE_CYCLES = 2 * gtpu_pkg::TABLE_ENTRIES + 16;
  localparam int STALL_LIMIT  = 20000;
  localparam int RAND_ITEMS   = 100;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] tid;
  } flow_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] tid;
    logic [63:0] pkts;
    logic [63:0] bytes;
    logic [15:0] len;
  } flow_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = gtpu_pkg::KIND_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [31:0] tunnel_id_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [31:0] found_tunnel_id_o;
  logic [63:0] packet_total_o;
  logic [63:0] byte_total_o;
  logic [15:0] packet_length_o;

  gtpu_teid_flow_counter dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .data_byte_i, .last_byte_i,
    .tunnel_id_i, .cfg_we_i, .cfg_wdata_i, .result_valid_o, .status_o,
    .found_tunnel_id_o, .packet_total_o, .byte_total_o, .packet_length_o
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [15:0] udp_port = gtpu_pkg::TUNNEL_PORT_RST;
  logic [7:0]  hdr_bytes [gtpu_pkg::HEADER_BYTES];
  logic [15:0] pkt_pos = '0;
  logic        tbl_valid [gtpu_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_tid   [gtpu_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_pkts  [gtpu_pkg::TABLE_ENTRIES];
  logic [63:0] tbl_bytes [gtpu_pkg::TABLE_ENTRIES];

  flow_item_t   pending_items [$];
  flow_result_t expected_results [$];
  logic [31:0]  known_tids [$];
  int           gap_pct = 13;
  int           errors = 0;
  int           stall_cnt = 0;

  initial begin
    for (int i = 0; i < gtpu_pkg::TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < gtpu_pkg::HEADER_BYTES; i++) hdr_bytes[i] = 8'h00;
  end

  function automatic logic [7:0] hdr_at(int p);
    return (p < gtpu_pkg::HEADER_BYTES) ? hdr_bytes[p] : 8'h00;
  endfunction

  function automatic logic [15:0] hdr16_at(int p);
    return {hdr_at(p), hdr_at(p + 1)};
  endfunction

  function automatic int lookup_tid(logic [31:0] id);
    for (int i = 0; i < gtpu_pkg::TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_tid[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [2:0] st, logic [31:0] id, logic [63:0] p,
                                      logic [63:0] b, logic [15:0] len);
    flow_result_t r;
    r.status = st; r.tid = id; r.pkts = p; r.bytes = b; r.len = len;
    expected_results.push_back(r);
  endfunction

  function automatic void count_flow(flow_item_t it);
    int e, u;
    logic [7:0] ihl_byte;
    logic [15:0] len;
    logic [31:0] teid;
    logic gtp;
    case (it.kind)
      gtpu_pkg::KIND_BYTE: begin
        if (pkt_pos < gtpu_pkg::HEADER_BYTES) hdr_bytes[pkt_pos] = it.data;
        if (pkt_pos != 16'hFFFF) pkt_pos++;
        if (it.last) begin
          len = pkt_pos;
          pkt_pos = '0;
          ihl_byte = hdr_at(14);
          u = int'(gtpu_pkg::ETH_LEN) + 4 * int'(ihl_byte[3:0]);
          gtp = len >= gtpu_pkg::MIN_LEN && hdr16_at(12) == gtpu_pkg::ETYPE_IPV4
                && hdr_at(23) == gtpu_pkg::PROTO_UDP
                && int'(len) >= u + 16
                && (hdr16_at(u) == udp_port || hdr16_at(u + 2) == udp_port);
          if (!gtp) begin
            push_result(gtpu_pkg::ST_NOT_GTP, '0, '0, '0, len);
          end else begin
            teid = {hdr16_at(u + 12), hdr16_at(u + 14)};
            e = lookup_tid(teid);
            if (e < 0) begin
              push_result(gtpu_pkg::ST_UNTRACKED, teid, '0, '0, len);
            end else begin
              tbl_pkts[e] += 64'd1;
              tbl_bytes[e] += 64'(len);
              push_result(gtpu_pkg::ST_COUNTED, teid, tbl_pkts[e], tbl_bytes[e], len);
            end
          end
        end
      end
      gtpu_pkg::KIND_TRACK: begin
        e = lookup_tid(it.tid);
        if (e >= 0) begin
          push_result(gtpu_pkg::ST_ALREADY, it.tid, tbl_pkts[e], tbl_bytes[e], '0);
        end else begin
          for (int i = 0; i < gtpu_pkg::TABLE_ENTRIES && e < 0; i++)
            if (!tbl_valid[i]) e = i;
          if (e < 0) begin
            push_result(gtpu_pkg::ST_FULL, it.tid, '0, '0, '0);
          end else begin
            tbl_valid[e] = 1'b1; tbl_tid[e] = it.tid;
            tbl_pkts[e] = '0; tbl_bytes[e] = '0;
            push_result(gtpu_pkg::ST_ADDED, it.tid, '0, '0, '0);
          end
        end
      end
      gtpu_pkg::KIND_READ: begin
        e = lookup_tid(it.tid);
        if (e >= 0) push_result(gtpu_pkg::ST_READ_HIT, it.tid, tbl_pkts[e], tbl_bytes[e], '0);
        else push_result(gtpu_pkg::ST_READ_MISS, it.tid, '0, '0, '0);
      end
      default: ;
    endcase
  endfunction

  // driver: a transfer happens when start is high and busy low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) count_flow(pending_items.pop_front());
      if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
        start       <= 1'b1;
        kind_i      <= pending_items[0].kind;
        data_byte_i <= pending_items[0].data;
        last_byte_i <= pending_items[0].last;
        tunnel_id_i <= pending_items[0].tid;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    flow_result_t x;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status_o);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (status_o !== x.status) begin
          $display("%0t: status exp %0d got %0d", $time, x.status, status_o);
          errors++;
        end
        if (found_tunnel_id_o !== x.tid) begin
          $display("%0t: teid exp %h got %h", $time, x.tid, found_tunnel_id_o);
          errors++;
        end
        if (packet_total_o !== x.pkts) begin
          $display("%0t: packets exp %0d got %0d", $time, x.pkts, packet_total_o);
          errors++;
        end
        if (byte_total_o !== x.bytes) begin
          $display("%0t: bytes exp %0d got %0d", $time, x.bytes, byte_total_o);
          errors++;
        end
        if (packet_length_o !== x.len) begin
          $display("%0t: length exp %0d got %0d", $time, x.len, packet_length_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_cmd(logic [1:0] k, logic [31:0] id);
    flow_item_t it;
    it.kind = k; it.tid = id; it.data = 8'($urandom); it.last = 1'($urandom);
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] pick_tid();
    if (known_tids.size() != 0 && $urandom_range(9) < 8)
      return known_tids[$urandom_range(known_tids.size() - 1)];
    return $urandom;
  endfunction

  // flaw: 0 none, 1 ethertype, 2 protocol, 3 port, 4 truncated
  // mix: interleave commands between bytes now and then
  function automatic void add_packet(int ihl, logic [31:0] teid, int flaw, int extra,
                                     bit on_dst, bit mix);
    logic [7:0] b [$];
    flow_item_t it;
    int u, len;
    u = 14 + 4 * ihl;
    len = u + 16 + extra;
    if (flaw == 4) len = $urandom_range(1, u + 15);
    for (int i = 0; i < len; i++) b.push_back(8'($urandom));
    if (len > 14) b[14] = {4'h4, 4'(ihl)};
    if (len > 13) begin b[12] = 8'h08; b[13] = 8'h00; end
    if (len > 23) b[23] = gtpu_pkg::PROTO_UDP;
    if (len >= u + 16) begin
      b[u + (on_dst ? 2 : 0)] = udp_port[15:8];
      b[u + (on_dst ? 2 : 0) + 1] = udp_port[7:0];
      {b[u + 12], b[u + 13], b[u + 14], b[u + 15]} = teid;
    end
    if (flaw == 1 && len > 13) b[13] = b[13] ^ (8'd1 << $urandom_range(7));
    if (flaw == 2 && len > 23) b[23] = b[23] ^ (8'd1 << $urandom_range(7));
    if (flaw == 3 && len >= u + 16) begin
      b[u] = ~udp_port[15:8]; b[u + 2] = ~udp_port[15:8];
    end
    for (int i = 0; i < len; i++) begin
      if (mix && $urandom_range(29) == 0) add_cmd(2'($urandom_range(1, 2)), pick_tid());
      it.kind = gtpu_pkg::KIND_BYTE; it.data = b[i]; it.last = (i == len - 1);
      it.tid = $urandom;
      pending_items.push_back(it);
    end
  endfunction

  task automatic drain_and_pause();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (PAUSE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_port(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    udp_port = v;
  endtask

  // n counts queued input items
  task automatic random_phase(int n);
    int r, base;
    logic [31:0] id;
    base = pending_items.size();
    while (pending_items.size() - base < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        add_packet($urandom_range(7) == 0 ? $urandom_range(15) : 5, pick_tid(), 0,
                   $urandom_range(20), 1'($urandom), 1'b1);
      end else if (r < 82) begin
        add_packet($urandom_range(15), pick_tid(), $urandom_range(1, 4),
                   $urandom_range(20), 1'($urandom), 1'b1);
      end else if (r < 90) begin
        id = $urandom;
        known_tids.push_back(id);
        add_cmd(gtpu_pkg::KIND_TRACK, $urandom_range(3) == 0 ? pick_tid() : id);
      end else if (r < 98) begin
        add_cmd(gtpu_pkg::KIND_READ, pick_tid());
      end else begin
        add_cmd(2'd3, $urandom);
      end
    end
  endtask

  initial begin
    flow_item_t it;
    logic [31:0] t1;
    t1 = 32'h1234_5678;
    known_tids.push_back(t1);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command and every status but table full, header extremes
    add_cmd(gtpu_pkg::KIND_READ, t1);
    add_cmd(gtpu_pkg::KIND_TRACK, t1);
    add_cmd(gtpu_pkg::KIND_TRACK, t1);
    add_cmd(gtpu_pkg::KIND_TRACK, 32'h0000_0000);
    add_cmd(gtpu_pkg::KIND_TRACK, 32'hFFFF_FFFF);
    add_packet(5, t1, 0, 0, 1'b0, 1'b0);
    add_packet(5, t1, 0, 7, 1'b1, 1'b0);
    add_packet(15, 32'hFFFF_FFFF, 0, 0, 1'b1, 1'b0);
    add_packet(0, 32'h0000_0000, 0, 10, 1'b0, 1'b0);
    add_packet(5, 32'hDEAD_BEEF, 0, 0, 1'b0, 1'b0);
    add_packet(5, t1, 1, 0, 1'b0, 1'b0);
    add_packet(5, t1, 2, 0, 1'b0, 1'b0);
    add_packet(5, t1, 3, 0, 1'b0, 1'b0);
    add_packet(5, t1, 4, 0, 1'b0, 1'b0);
    it.kind = gtpu_pkg::KIND_BYTE; it.data = 8'hFF; it.last = 1'b1; it.tid = '0;
    pending_items.push_back(it);
    add_cmd(2'd3, 32'hFFFF_FFFF);
    add_cmd(gtpu_pkg::KIND_READ, t1);
    add_cmd(gtpu_pkg::KIND_READ, 32'h0BAD_F00D);
    random_phase(RAND_ITEMS);
    drain_and_pause();

    write_port(16'hFFFF);
    gap_pct = 67;
    random_phase(RAND_ITEMS);
    drain_and_pause();

    write_port(16'h0000);
    gap_pct = 0;
    random_phase(RAND_ITEMS);
    drain_and_pause();

    write_port(16'($urandom));
    random_phase(20);
    add_cmd(gtpu_pkg::KIND_READ, t1);
    drain_and_pause();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
